// ===== sv/isv_pkg.sv =====
// shared types, codes and the byte-wide crc step of the image validator
`timescale 1ns / 1ps
package isv_pkg;

  // command codes carried by each request
  localparam logic [1:0] CmdData    = 2'd0;
  localparam logic [1:0] CmdFinish  = 2'd1;
  localparam logic [1:0] CmdRestart = 2'd2;

  // error codes, the first one recorded sticks
  localparam logic [3:0] ErrNone       = 4'd0;
  localparam logic [3:0] ErrIncomplete = 4'd1;
  localparam logic [3:0] ErrShort      = 4'd2;
  localparam logic [3:0] ErrLong       = 4'd3;
  localparam logic [3:0] ErrMagic      = 4'd4;
  localparam logic [3:0] ErrVersion    = 4'd5;
  localparam logic [3:0] ErrHdrSize    = 4'd6;
  localparam logic [3:0] ErrDims       = 4'd7;
  localparam logic [3:0] ErrFrameSize  = 4'd8;
  localparam logic [3:0] ErrGen        = 4'd9;
  localparam logic [3:0] ErrPalette    = 4'd10;
  localparam logic [3:0] ErrCrc        = 4'd11;

  // configuration register indexes
  localparam logic [2:0] CfgVersion  = 3'd0;
  localparam logic [2:0] CfgWidth    = 3'd1;
  localparam logic [2:0] CfgHeight   = 3'd2;
  localparam logic [2:0] CfgFrame    = 3'd3;
  localparam logic [2:0] CfgMaxColor = 3'd4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // configuration reset values
  localparam logic [31:0] RstVersion  = 32'd1;
  localparam logic [15:0] RstWidth    = 16'd800;
  localparam logic [15:0] RstHeight   = 16'd480;
  localparam logic [23:0] RstFrame    = 24'd192000;
  localparam logic [3:0]  RstMaxColor = 4'd6;

  // palette code that is never allowed
  localparam logic [3:0] BadColorCode = 4'd4;

  // crc-32, reflected form
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // file magic, bytes 0 to 7 of the header
  localparam logic [7:0] MagicBytes [8] = '{8'h45, 8'h50, 8'h44, 8'h49,
                                            8'h4D, 8'h47, 8'h00, 8'h00};

  typedef struct packed {
    logic [31:0] version;
    logic [15:0] width;
    logic [15:0] height;
    logic [23:0] frame;
    logic [3:0]  max_color;
  } isv_cfg_t;

  // classified request passed from front to back
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       pal_ok;
  } isv_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] error_code;
    logic       done;
    logic       header_ok;
  } isv_result_t;

  // one byte through the reflected crc, bit by bit
  function automatic logic [31:0] crc_byte(logic [31:0] c_in, logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

// ===== sv/isv_fifo.sv =====
// small first-in first-out queue built from registers
`timescale 1ns / 1ps
module isv_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== sv/isv_front.sv =====
// front end: takes requests and classifies the palette codes of each byte
`timescale 1ns / 1ps
module isv_front (
  input  logic              push_i,
  input  logic              q_full_i,
  input  logic [1:0]        cmd_i,
  input  logic [7:0]        byte_value_i,
  input  logic [3:0]        max_color_i,
  output logic              q_push_o,
  output isv_pkg::isv_item_t item_o
);

  import isv_pkg::*;

  logic hi_ok, lo_ok;

  // a code passes if it is within range and not the reserved code
  assign hi_ok = (byte_value_i[7:4] <= max_color_i) && (byte_value_i[7:4] != BadColorCode);
  assign lo_ok = (byte_value_i[3:0] <= max_color_i) && (byte_value_i[3:0] != BadColorCode);

  assign q_push_o      = push_i && !q_full_i;
  assign item_o.cmd    = cmd_i;
  assign item_o.data   = byte_value_i;
  assign item_o.pal_ok = hi_ok && lo_ok;

endmodule

// ===== sv/isv_back.sv =====
// back end: header checks, body counting, crc and the sticky error state
`timescale 1ns / 1ps
module isv_back #(
  parameter int unsigned HEADER_BYTES = 40
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  isv_pkg::isv_cfg_t   cfg_i,
  input  isv_pkg::isv_item_t  item_i,
  input  logic                item_empty_i,
  output logic                item_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output isv_pkg::isv_result_t res_o
);

  import isv_pkg::*;

  localparam int unsigned HcW = $clog2(HEADER_BYTES + 1);
  localparam logic [31:0] HdrSize32 = 32'(HEADER_BYTES);

  logic [HcW-1:0] hcnt_q, hcnt_d;
  logic [23:0]    body_q, body_d;
  logic [31:0]    crc_q, crc_d;
  logic [31:0]    crc_ref_q, crc_ref_d;
  logic [3:0]     err_q, err_d;
  logic           done_q, done_d;
  logic           hdr_ok_q, hdr_ok_d;
  logic [4:0]     mis_q, mis_d;
  logic           gen_q, gen_d;

  logic           take;
  logic           hdr_full, too_long, last_hdr;
  logic [HcW-1:0] pos;
  logic [4:0]     lane_off;
  logic [7:0]     b;
  logic [4:0]     mis_cur, mis_all;
  logic           gen_all;
  logic [3:0]     hdr_err;
  logic [31:0]    width32, height32, frame32;

  assign take       = !item_empty_i && !res_full_i;
  assign item_pop_o = take;
  assign res_push_o = take;

  assign pos      = hcnt_q;
  assign lane_off = {pos[1:0], 3'b000};
  assign b        = item_i.data;
  assign hdr_full = (hcnt_q == HcW'(HEADER_BYTES));
  assign last_hdr = (hcnt_q == HcW'(HEADER_BYTES - 1));
  assign too_long = hdr_full && (body_q >= cfg_i.frame);

  // configuration values widened to the header field size
  assign width32  = {16'd0, cfg_i.width};
  assign height32 = {16'd0, cfg_i.height};
  assign frame32  = {8'd0, cfg_i.frame};

  // per-byte header field compare, bits: magic, version, size, dims, frame
  always_comb begin
    mis_cur    = '0;
    mis_cur[0] = (pos < HcW'(8)) && (b != MagicBytes[pos[2:0]]);
    mis_cur[1] = (pos >= HcW'(8)) && (pos < HcW'(12)) &&
                 (b != cfg_i.version[lane_off +: 8]);
    mis_cur[2] = (pos >= HcW'(12)) && (pos < HcW'(16)) && (b != HdrSize32[lane_off +: 8]);
    if ((pos >= HcW'(16)) && (pos < HcW'(20))) begin
      mis_cur[3] = (b != width32[lane_off +: 8]);
    end else if ((pos >= HcW'(20)) && (pos < HcW'(24))) begin
      mis_cur[3] = (b != height32[lane_off +: 8]);
    end
    mis_cur[4] = (pos >= HcW'(24)) && (pos < HcW'(28)) &&
                 (b != frame32[lane_off +: 8]);
  end

  assign mis_all = mis_q | mis_cur;
  assign gen_all = gen_q || ((pos >= HcW'(32)) && (pos < HcW'(40)) && (b != 8'd0));

  // header verdict in check order
  always_comb begin
    if (mis_all[0]) begin
      hdr_err = ErrMagic;
    end else if (mis_all[1]) begin
      hdr_err = ErrVersion;
    end else if (mis_all[2]) begin
      hdr_err = ErrHdrSize;
    end else if (mis_all[3]) begin
      hdr_err = ErrDims;
    end else if (mis_all[4]) begin
      hdr_err = ErrFrameSize;
    end else if (!gen_all) begin
      hdr_err = ErrGen;
    end else begin
      hdr_err = ErrNone;
    end
  end

  // next state for the request at the head of the queue
  always_comb begin
    hcnt_d    = hcnt_q;
    body_d    = body_q;
    crc_d     = crc_q;
    crc_ref_d = crc_ref_q;
    err_d     = err_q;
    done_d    = done_q;
    hdr_ok_d  = hdr_ok_q;
    mis_d     = mis_q;
    gen_d     = gen_q;
    if (take) begin
      case (item_i.cmd)
        CmdData: begin
          if ((err_q == ErrNone) && !done_q) begin
            if (too_long) begin
              err_d = ErrLong;
            end else if (!hdr_full) begin
              hcnt_d = hcnt_q + 1'b1;
              mis_d  = mis_all;
              gen_d  = gen_all;
              if ((pos >= HcW'(28)) && (pos < HcW'(32))) begin
                crc_ref_d[lane_off +: 8] = b;
              end
              if (last_hdr) begin
                if (hdr_err == ErrNone) begin
                  hdr_ok_d = 1'b1;
                end else begin
                  err_d = hdr_err;
                end
              end
            end else if (!item_i.pal_ok) begin
              err_d = ErrPalette;
            end else begin
              crc_d  = crc_byte(crc_q, b);
              body_d = body_q + 1'b1;
            end
          end
        end
        CmdFinish: begin
          if (!done_q) begin
            done_d = 1'b1;
            if (err_q == ErrNone) begin
              if (!hdr_full) begin
                err_d = ErrIncomplete;
              end else if (body_q < cfg_i.frame) begin
                err_d = ErrShort;
              end else if ((crc_q ^ CrcInit) != crc_ref_q) begin
                err_d = ErrCrc;
              end
            end
          end
        end
        CmdRestart: begin
          hcnt_d    = '0;
          body_d    = '0;
          crc_d     = CrcInit;
          crc_ref_d = '0;
          err_d     = ErrNone;
          done_d    = 1'b0;
          hdr_ok_d  = 1'b0;
          mis_d     = '0;
          gen_d     = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_o.ok         = (err_d == ErrNone);
  assign res_o.error_code = err_d;
  assign res_o.done       = done_d;
  assign res_o.header_ok  = hdr_ok_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q    <= '0;
      body_q    <= '0;
      crc_q     <= CrcInit;
      crc_ref_q <= '0;
      err_q     <= ErrNone;
      done_q    <= 1'b0;
      hdr_ok_q  <= 1'b0;
      mis_q     <= '0;
      gen_q     <= 1'b0;
    end else begin
      hcnt_q    <= hcnt_d;
      body_q    <= body_d;
      crc_q     <= crc_d;
      crc_ref_q <= crc_ref_d;
      err_q     <= err_d;
      done_q    <= done_d;
      hdr_ok_q  <= hdr_ok_d;
      mis_q     <= mis_d;
      gen_q     <= gen_d;
    end
  end

`ifndef ASSERT_OFF
  // a recorded error only leaves on restart
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((err_q != ErrNone) && !(take && (item_i.cmd == CmdRestart))) |=> (err_q == $past(err_q)))
    else $error("error code changed without restart");

  // finish flag only leaves on restart
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !(take && (item_i.cmd == CmdRestart))) |=> done_q)
    else $error("finish flag dropped without restart");

  // a passed header means the whole header was taken
  a_hdr_ok_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_ok_q |-> hdr_full)
    else $error("header flagged good before it was complete");

  // body bytes only count after the header
  a_body_after_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (body_q != '0) |-> hdr_ok_q)
    else $error("body bytes counted without a good header");
`endif

endmodule

// ===== sv/image_stream_validator_crc32.sv =====
// top level: config registers, front end, request queue, back end, result queue
// path: an accepted request enters the request queue; the back end takes it from the
//   head of that queue and writes its result into the result queue when that queue has room
// throughput: one request per cycle while the result queue is not full
// reset: rst_ni low clears both queues and all validator state at once, and
//   loads the configuration registers with their default values
`timescale 1ns / 1ps
module image_stream_validator_crc32 #(
  parameter int unsigned HEADER_BYTES = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request side
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  cmd_i,
  input  logic [7:0]                  byte_value_i,
  // result side
  output logic                        empty,
  input  logic                        pop,
  output logic                        ok_o,
  output logic [3:0]                  error_code_o,
  output logic                        done_res_o,
  output logic                        header_ok_o,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [isv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [isv_pkg::CfgDataW-1:0] cfg_wdata_i
);

  import isv_pkg::*;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned ItemW      = $bits(isv_item_t);
  localparam int unsigned ResW       = $bits(isv_result_t);

  isv_cfg_t    cfg_q;
  isv_item_t   front_item, back_item;
  isv_result_t back_res, out_res;
  logic        req_push, req_full, req_empty, req_pop;
  logic        res_push, res_full;
  logic [ItemW-1:0] back_item_bits;
  logic [ResW-1:0]  out_res_bits;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.version   <= RstVersion;
      cfg_q.width     <= RstWidth;
      cfg_q.height    <= RstHeight;
      cfg_q.frame     <= RstFrame;
      cfg_q.max_color <= RstMaxColor;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgVersion:  cfg_q.version   <= cfg_wdata_i;
        CfgWidth:    cfg_q.width     <= cfg_wdata_i[15:0];
        CfgHeight:   cfg_q.height    <= cfg_wdata_i[15:0];
        CfgFrame:    cfg_q.frame     <= cfg_wdata_i[23:0];
        CfgMaxColor: cfg_q.max_color <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // request classification
  isv_front u_front (
    .push_i       (push),
    .q_full_i     (req_full),
    .cmd_i        (cmd_i),
    .byte_value_i (byte_value_i),
    .max_color_i  (cfg_q.max_color),
    .q_push_o     (req_push),
    .item_o       (front_item)
  );

  assign full = req_full;

  // queue between front and back
  isv_fifo #(
    .WIDTH (ItemW),
    .DEPTH (QueueDepth)
  ) u_req_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_push),
    .wdata_i (front_item),
    .full_o  (req_full),
    .pop_i   (req_pop),
    .rdata_o (back_item_bits),
    .empty_o (req_empty)
  );

  assign back_item = isv_item_t'(back_item_bits);

  // validator state
  isv_back #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (back_item),
    .item_empty_i (req_empty),
    .item_pop_o   (req_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (back_res)
  );

  // result queue toward the consumer
  isv_fifo #(
    .WIDTH (ResW),
    .DEPTH (QueueDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_res_bits),
    .empty_o (empty)
  );

  assign out_res      = isv_result_t'(out_res_bits);
  assign ok_o         = out_res.ok;
  assign error_code_o = out_res.error_code;
  assign done_res_o   = out_res.done;
  assign header_ok_o  = out_res.header_ok;

endmodule
